FILE: hdl/bla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bla_pkg;

   localparam int DEF_NUM_SPLITS    = 7;
   localparam int DEF_ENVELOPE_BITS = 24;

   // band index for up to fifteen splits
   localparam int INDEX_BITS = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam int COEFF_BITS       = 16;
   localparam int LOW_COEFF_COUNT  = 4;
   localparam int PACKED_COEFF_MAX = 7;

   localparam logic [15:0] RESET_TARGET_GAIN   = 16'd4096;
   localparam logic [15:0] RESET_TARGET_SMOOTH = 16'd0;
   localparam logic [15:0] RESET_GLIDE_RATE    = 16'd137;
   localparam logic [15:0] RESET_FLOOR_LEVEL   = 16'd0;
   localparam logic [31:0] RESET_INVERSE_SPAN  = 32'd65536;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SPLIT_LOW,
      REG_SPLIT_HIGH,
      REG_TARGET_GAIN,
      REG_TARGET_SMOOTH,
      REG_GLIDE_RATE,
      REG_FLOOR_LEVEL,
      REG_INVERSE_SPAN
   } reg_index_type;

   typedef struct packed {
      logic [63:0] split_coeffs_low;
      logic [47:0] split_coeffs_high;
      logic [15:0] target_gain;
      logic [15:0] target_band_smoothing;
      logic [15:0] glide_rate;
      logic [15:0] floor_level;
      logic [31:0] inverse_span;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_GAIN,
      OP_SMOOTH,
      OP_DET,
      OP_SPLIT,
      OP_BAND,
      OP_TOP,
      OP_NORM_LO,
      OP_NORM_HI
   } op_type;

   typedef struct packed {
      logic                  capture;
      logic                  issue;
      logic                  writeback;
      logic                  load_out;
      op_type                op;
      logic [INDEX_BITS-1:0] index;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/bla_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bla_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;
   logic               mono_source;
   logic               end_of_block;

   modport source (
      output valid, left_sample, right_sample, mono_source, end_of_block,
      input  ready
   );

   modport sink (
      input  valid, left_sample, right_sample, mono_source, end_of_block,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/bla_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bla_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  band_number;
   logic [15:0] band_level;
   logic        last_band;

   modport source (
      output valid, band_number, band_level, last_band,
      input  ready
   );

   modport sink (
      input  valid, band_number, band_level, last_band,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/bla_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module bla_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [bla_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bla_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output bla_pkg::cfg_type                    cfg
);
   import bla_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_SPLIT_LOW:     cfg_in.split_coeffs_low      = csr_data;
            REG_SPLIT_HIGH:    cfg_in.split_coeffs_high     = csr_data[47:0];
            REG_TARGET_GAIN:   cfg_in.target_gain           = csr_data[15:0];
            REG_TARGET_SMOOTH: cfg_in.target_band_smoothing = csr_data[15:0];
            REG_GLIDE_RATE:    cfg_in.glide_rate            = csr_data[15:0];
            REG_FLOOR_LEVEL:   cfg_in.floor_level           = csr_data[15:0];
            REG_INVERSE_SPAN:  cfg_in.inverse_span          = csr_data[31:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.split_coeffs_low      <= '0;
         cfg_ff.split_coeffs_high     <= '0;
         cfg_ff.target_gain           <= RESET_TARGET_GAIN;
         cfg_ff.target_band_smoothing <= RESET_TARGET_SMOOTH;
         cfg_ff.glide_rate            <= RESET_GLIDE_RATE;
         cfg_ff.floor_level           <= RESET_FLOOR_LEVEL;
         cfg_ff.inverse_span          <= RESET_INVERSE_SPAN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/bla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bla_ctrl #(
   parameter int NUM_SPLITS = bla_pkg::DEF_NUM_SPLITS
) (
   input  logic                 clock,
   input  logic                 reset,
   bla_req_if.sink              req,
   input  bla_pkg::status_type  status,
   output bla_pkg::cmd_type     cmd
);
   import bla_pkg::*;

   localparam int BW = $clog2(NUM_SPLITS + 1);
   localparam logic [BW-1:0] LAST_SPLIT = BW'(NUM_SPLITS - 1);
   localparam logic [BW-1:0] TOP_BAND   = BW'(NUM_SPLITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WB
   } state_type;

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [BW-1:0] idx_ff, idx_in;
   logic          emit_ff, emit_in;
   logic          accept;
   logic          step_done;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   // output load waits for a free result register
   assign step_done = (state_ff == ST_WB) && ((op_ff != OP_NORM_HI) || status.out_free);

   always_comb begin
      cmd.capture   = accept;
      cmd.issue     = (state_ff == ST_ISSUE);
      cmd.writeback = step_done;
      cmd.load_out  = step_done && (op_ff == OP_NORM_HI);
      cmd.op        = op_ff;
      cmd.index     = INDEX_BITS'(idx_ff);
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      emit_in  = emit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ISSUE;
               op_in    = OP_GAIN;
               idx_in   = '0;
               emit_in  = req.end_of_block;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            if (step_done) begin
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_GAIN:   op_in = OP_SMOOTH;
                  OP_SMOOTH: op_in = OP_DET;
                  OP_DET: begin
                     op_in  = OP_SPLIT;
                     idx_in = '0;
                  end
                  OP_SPLIT:  op_in = OP_BAND;
                  OP_BAND: begin
                     if (idx_ff == LAST_SPLIT) begin
                        op_in  = OP_TOP;
                        idx_in = TOP_BAND;
                     end else begin
                        op_in  = OP_SPLIT;
                        idx_in = idx_ff + BW'(1);
                     end
                  end
                  OP_TOP: begin
                     if (emit_ff) begin
                        op_in  = OP_NORM_LO;
                        idx_in = '0;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  OP_NORM_LO: op_in = OP_NORM_HI;
                  OP_NORM_HI: begin
                     if (idx_ff == TOP_BAND) begin
                        state_in = ST_IDLE;
                     end else begin
                        op_in  = OP_NORM_LO;
                        idx_in = idx_ff + BW'(1);
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_GAIN;
         idx_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bla_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bla_dp #(
   parameter int NUM_SPLITS    = bla_pkg::DEF_NUM_SPLITS,
   parameter int ENVELOPE_BITS = bla_pkg::DEF_ENVELOPE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bla_pkg::cfg_type     cfg,
   input  bla_pkg::cmd_type     cmd,
   output bla_pkg::status_type  status,
   input  logic signed [15:0]   left_sample,
   input  logic signed [15:0]   right_sample,
   input  logic                 mono_source,
   bla_rsp_if.source            rsp
);
   import bla_pkg::*;

   localparam int EB = ENVELOPE_BITS;
   localparam int NB = NUM_SPLITS + 1;
   localparam int BW = $clog2(NB);
   localparam int SW = (NUM_SPLITS > 1) ? $clog2(NUM_SPLITS) : 1;
   localparam int AW = EB + 2;
   localparam int PW = AW + 17;
   localparam int DW = (EB > 21) ? EB : 21;
   localparam logic [EB-1:0] ENV_MAX = {EB{1'b1}};

   // envelope state
   logic [EB-1:0] split_env_ff [NUM_SPLITS];
   logic [EB-1:0] band_env_ff [NB];
   logic [15:0]   gain_ff;
   logic [15:0]   smooth_ff;

   // per-sample working registers
   logic [16:0]          mag_ff;
   logic [EB-1:0]        det_ff;
   logic [EB-1:0]        cur_split_ff;
   logic [EB-1:0]        prev_split_ff;
   logic signed [PW-1:0] prod_ff;
   logic [EB:0]          lo_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  band_number_ff;
   logic [15:0] band_level_ff;
   logic        last_band_ff;

   logic [COEFF_BITS-1:0] coeff_vec [NUM_SPLITS];
   logic [SW-1:0]         sidx;
   logic [BW-1:0]         bidx;

   logic signed [16:0] sum_in;
   logic [16:0]        mag_in;

   logic [15:0] gl_now, gl_tgt, gl_d, gl_step, glide_in;
   logic        gl_up;
   logic [32:0] gl_rnd;

   logic [EB-1:0] split_sel, band_sel;
   logic [EB-1:0] band_diff, top_diff, norm_diff;
   logic [EB-1:0] env_x, env_y;
   logic [15:0]   coef;

   logic signed [AW-1:0] mul_a;
   logic [15:0]          mul_b;
   logic signed [PW-1:0] prod_in;
   logic [PW-1:0]        prod_u;

   logic [32:0]          det_rnd;
   logic [20:0]          det_raw;
   logic [DW-1:0]        det_wide;
   logic [EB-1:0]        det_in;
   logic signed [PW-1:0] onep_rnd, onep_shift;
   logic [PW-1:0]        env_sum;
   logic [EB-1:0]        env_in;
   logic [PW-1:0]        lo_rnd, hi_sum;
   logic [EB:0]          lo_in;
   logic [15:0]          level_in;

   for (genvar i = 0; i < NUM_SPLITS; i++) begin : g_coeff
      if (i < LOW_COEFF_COUNT) begin : g_low
         assign coeff_vec[i] = cfg.split_coeffs_low[COEFF_BITS*i +: COEFF_BITS];
      end else if (i < PACKED_COEFF_MAX) begin : g_high
         assign coeff_vec[i] =
            cfg.split_coeffs_high[COEFF_BITS*(i-LOW_COEFF_COUNT) +: COEFF_BITS];
      end else begin : g_none
         assign coeff_vec[i] = '0;
      end
   end

   assign sidx = cmd.index[SW-1:0];
   assign bidx = cmd.index[BW-1:0];

   // mono mix and rectify at capture
   always_comb begin
      sum_in = {left_sample[15], left_sample}
             + (mono_source ? {left_sample[15], left_sample}
                            : {right_sample[15], right_sample});
      mag_in = sum_in[16] ? 17'(-sum_in) : 17'(sum_in);
   end

   // operand selection
   always_comb begin
      gl_now = (cmd.op == OP_SMOOTH) ? smooth_ff : gain_ff;
      gl_tgt = (cmd.op == OP_SMOOTH) ? cfg.target_band_smoothing : cfg.target_gain;
      gl_up  = (gl_tgt >= gl_now);
      gl_d   = gl_up ? (gl_tgt - gl_now) : (gl_now - gl_tgt);

      split_sel = split_env_ff[sidx];
      band_sel  = band_env_ff[bidx];
      band_diff = (cur_split_ff > prev_split_ff) ? (cur_split_ff - prev_split_ff) : '0;
      top_diff  = (det_ff > prev_split_ff) ? (det_ff - prev_split_ff) : '0;
      norm_diff = (band_sel > EB'(cfg.floor_level)) ? (band_sel - EB'(cfg.floor_level))
                                                    : '0;

      env_x = '0;
      env_y = '0;
      coef  = '0;
      case (cmd.op)
         OP_SPLIT: begin
            env_x = det_ff;
            env_y = split_sel;
            coef  = coeff_vec[sidx];
         end
         OP_BAND: begin
            env_x = band_diff;
            env_y = band_sel;
            coef  = smooth_ff;
         end
         OP_TOP: begin
            env_x = top_diff;
            env_y = band_sel;
            coef  = smooth_ff;
         end
         default: begin
            env_x = '0;
            env_y = '0;
            coef  = '0;
         end
      endcase

      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_GAIN, OP_SMOOTH: begin
            mul_a = AW'(gl_d);
            mul_b = cfg.glide_rate;
         end
         OP_DET: begin
            mul_a = AW'(mag_ff);
            mul_b = gain_ff;
         end
         OP_SPLIT, OP_BAND, OP_TOP: begin
            // one pole as x + c*(y - x)
            mul_a = AW'(env_y) - AW'(env_x);
            mul_b = coef;
         end
         OP_NORM_LO: begin
            mul_a = AW'(norm_diff);
            mul_b = cfg.inverse_span[15:0];
         end
         OP_NORM_HI: begin
            mul_a = AW'(norm_diff);
            mul_b = cfg.inverse_span[31:16];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      prod_in = mul_a * $signed({1'b0, mul_b});
   end

   // writeback arithmetic
   always_comb begin
      prod_u = prod_ff;

      gl_rnd   = prod_u[32:0] + 33'd65535;
      gl_step  = gl_rnd[31:16];
      glide_in = gl_up ? (gl_now + gl_step) : (gl_now - gl_step);

      det_rnd  = prod_u[32:0] + 33'd2048;
      det_raw  = det_rnd[32:12];
      det_wide = DW'(det_raw);
      det_in   = (det_wide > DW'(ENV_MAX)) ? ENV_MAX : det_wide[EB-1:0];

      onep_rnd   = prod_ff + PW'(32768);
      onep_shift = onep_rnd >>> 16;
      env_sum    = onep_shift + PW'(env_x);
      env_in     = env_sum[EB-1:0];

      lo_rnd   = prod_u + PW'(32768);
      lo_in    = lo_rnd[EB+16:16];
      hi_sum   = prod_u + PW'(lo_ff);
      level_in = (hi_sum > PW'(16'hFFFF)) ? 16'hFFFF : hi_sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= RESET_TARGET_GAIN;
         smooth_ff    <= RESET_TARGET_SMOOTH;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SPLITS; i++) begin
            split_env_ff[i] <= '0;
         end
         for (int i = 0; i < NB; i++) begin
            band_env_ff[i] <= '0;
         end
      end else begin
         if (cmd.writeback) begin
            case (cmd.op)
               OP_GAIN:        gain_ff <= glide_in;
               OP_SMOOTH:      smooth_ff <= glide_in;
               OP_SPLIT:       split_env_ff[sidx] <= env_in;
               OP_BAND, OP_TOP: band_env_ff[bidx] <= env_in;
               default: begin
               end
            endcase
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff        <= mag_in;
         prev_split_ff <= '0;
      end
      if (cmd.issue) begin
         prod_ff <= prod_in;
      end
      if (cmd.writeback) begin
         case (cmd.op)
            OP_DET:     det_ff <= det_in;
            OP_SPLIT:   cur_split_ff <= env_in;
            OP_BAND:    prev_split_ff <= cur_split_ff;
            OP_NORM_LO: lo_ff <= lo_in;
            default: begin
            end
         endcase
      end
      if (cmd.load_out) begin
         band_number_ff <= 3'(bidx);
         band_level_ff  <= level_in;
         last_band_ff   <= (bidx == BW'(NUM_SPLITS));
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp.ready;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.band_number = band_number_ff;
   assign rsp.band_level  = band_level_ff;
   assign rsp.last_band   = last_band_ff;

endmodule

`default_nettype wire

FILE: hdl/band_level_analyzer.sv
`timescale 1ns / 1ps
`default_nettype none

// Eight-band level analyzer: each accepted sample is mixed to mono, rectified,
// scaled by a gliding gain and fed to NUM_SPLITS parallel one-pole lowpass
// envelopes; the positive differences between neighboring envelopes (plus the
// part above the last split) are smoothed per band, and a sample flagged
// end_of_block is followed by NUM_SPLITS+1 results, lowest band first, each
// floored, scaled by the inverse span and clamped to Q0.16. All arithmetic goes
// through one shared multiplier in two steps per operation (operand select
// into the product register, then writeback), so a sample occupies the block
// until its last writeback and no new sample is taken before then; a band
// result's writeback also waits while the result register is full. The user
// must write registers only while the block is idle; the block does not enforce it.

module band_level_analyzer #(
   parameter int NUM_SPLITS    = bla_pkg::DEF_NUM_SPLITS,
   parameter int ENVELOPE_BITS = bla_pkg::DEF_ENVELOPE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   bla_req_if.sink                             req_ch,
   bla_rsp_if.source                           rsp_ch,
   input  logic                                csr_write,
   input  logic [bla_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bla_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import bla_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   bla_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bla_ctrl #(
      .NUM_SPLITS (NUM_SPLITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .status (status),
      .cmd    (cmd)
   );

   bla_dp #(
      .NUM_SPLITS    (NUM_SPLITS),
      .ENVELOPE_BITS (ENVELOPE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .left_sample  (req_ch.left_sample),
      .right_sample (req_ch.right_sample),
      .mono_source  (req_ch.mono_source),
      .rsp          (rsp_ch)
   );

endmodule

`default_nettype wire
